// ===== rtl/analog_quadrature_tracker_assert.svh =====
// assertion macros for the analog quadrature tracker
// used by analog_quadrature_tracker.sv; expects clk and rst_n in scope
`ifndef ANALOG_QUADRATURE_TRACKER_ASSERT_SVH
`define ANALOG_QUADRATURE_TRACKER_ASSERT_SVH

// same-cycle implication, quiet during reset
`define AQT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aqt assertion failed");

// next-cycle implication, quiet during reset
`define AQT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aqt assertion failed");

`endif

// ===== rtl/aqt_pkg.sv =====
// shared widths, codes and lane control type for the analog quadrature tracker
// no dependencies; used by every module of the block
package aqt_pkg;

    localparam int SampleBits = 12;   // converter sample width, 8 to 16
    localparam int ResBits    = 16;   // residual accumulator width
    localparam int ShiftBits  = 4;    // decay exponent register width
    localparam int HeightBits = 12;   // minimum height register width
    localparam int CmpBits    = 17;   // common width for height compares
    localparam int DataBits   = 32;   // configuration data width
    localparam int AddrBits   = 3;    // configuration byte address width

    localparam logic [ShiftBits-1:0]  DecayShiftReset = ShiftBits'(4);
    localparam logic [HeightBits-1:0] MinHeightReset  = HeightBits'(256);

    // register index, taken from the word address bit
    localparam logic RegDecayShift = 1'b0;
    localparam logic RegMinHeight  = 1'b1;

    // quadrature step codes
    localparam logic signed [1:0] DirNone = 2'sb00;
    localparam logic signed [1:0] DirFwd  = 2'sb01;
    localparam logic signed [1:0] DirBwd  = 2'sb11;

    typedef logic [SampleBits-1:0] sample_t;
    typedef logic [ResBits-1:0]    residual_t;

    // per-cycle control from the top level to both lanes
    typedef struct packed {
        logic load;      // request accepted into the envelope stage
        logic prime;     // first request since reset, envelopes take the sample
        logic advance;   // binarising stage hands its result to the output
    } lane_ctrl_t;

endpackage

// ===== rtl/aqt_lane.sv =====
// one channel lane: envelope tracking stage, then hysteresis binarising stage
// depends on aqt_pkg
module aqt_lane (
    input  logic                             clk,
    input  logic                             rst_n,
    input  aqt_pkg::lane_ctrl_t              ctrl,
    input  logic [aqt_pkg::ShiftBits-1:0]    decay_shift,
    input  logic [aqt_pkg::HeightBits-1:0]   min_height,
    input  aqt_pkg::sample_t                 sample,
    output logic                             level_old,
    output logic                             level_new
);

    aqt_pkg::sample_t   lo_reg, lo_next, hi_reg, hi_next;
    aqt_pkg::residual_t rlo_reg, rlo_next, rhi_reg, rhi_next;
    aqt_pkg::sample_t   smp_p_reg, lo_p_reg, hi_p_reg;
    logic               level_reg, level_next;

    aqt_pkg::sample_t   lo_cur, hi_cur, lo_1, hi_1, height, quarter;
    aqt_pkg::residual_t rlo_cur, rhi_cur, rlo_1, rhi_1, rlo_sh, rhi_sh, keep;

    // envelope update, first stage
    always_comb
    begin
        lo_cur  = ctrl.prime ? sample : lo_reg;
        hi_cur  = ctrl.prime ? sample : hi_reg;
        rlo_cur = ctrl.prime ? '0 : rlo_reg;
        rhi_cur = ctrl.prime ? '0 : rhi_reg;
        keep    = ~({aqt_pkg::ResBits{1'b1}} << decay_shift);

        if (sample < lo_cur)
        begin
            lo_1  = sample;
            rlo_1 = rlo_cur;
        end
        else
        begin
            lo_1  = lo_cur;
            rlo_1 = rlo_cur + aqt_pkg::ResBits'(sample - lo_cur);
        end

        if (sample > hi_cur)
        begin
            hi_1  = sample;
            rhi_1 = rhi_cur;
        end
        else
        begin
            hi_1  = hi_cur;
            rhi_1 = rhi_cur + aqt_pkg::ResBits'(hi_cur - sample);
        end

        rlo_sh   = rlo_1 >> decay_shift;
        rhi_sh   = rhi_1 >> decay_shift;
        lo_next  = lo_1 + rlo_sh[aqt_pkg::SampleBits-1:0];
        hi_next  = hi_1 - rhi_sh[aqt_pkg::SampleBits-1:0];
        rlo_next = rlo_1 & keep;
        rhi_next = rhi_1 & keep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg  <= '0;
            hi_reg  <= '0;
            rlo_reg <= '0;
            rhi_reg <= '0;
        end
        else if (ctrl.load)
        begin
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
            rlo_reg <= rlo_next;
            rhi_reg <= rhi_next;
        end
    end

    // payload into the binarising stage
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            smp_p_reg <= sample;
            lo_p_reg  <= lo_next;
            hi_p_reg  <= hi_next;
        end
    end

    // hysteresis at a quarter of the height from each end
    always_comb
    begin
        height     = hi_p_reg - lo_p_reg;
        quarter    = height >> 2;
        level_next = level_reg;
        if ((hi_p_reg >= lo_p_reg) &&
            (aqt_pkg::CmpBits'(height) >= aqt_pkg::CmpBits'(min_height)))
        begin
            priority if (smp_p_reg < lo_p_reg + quarter)
                level_next = 1'b0;
            else if (smp_p_reg > hi_p_reg - quarter)
                level_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            level_reg <= 1'b0;
        else if (ctrl.advance)
            level_reg <= level_next;
    end

    assign level_old = level_reg;
    assign level_new = level_next;

endmodule

// ===== rtl/aqt_merge.sv =====
// merging stage: quadrature decode of the two lanes' level changes
// depends on aqt_pkg
module aqt_merge (
    input  logic              old_a,
    input  logic              old_b,
    input  logic              new_a,
    input  logic              new_b,
    output logic signed [1:0] direction
);

    logic ch_a, ch_b;

    always_comb
    begin
        ch_a = new_a ^ old_a;
        ch_b = new_b ^ old_b;
        unique case ({ch_a, ch_b})
            2'b10:   direction = (new_a == new_b) ? aqt_pkg::DirFwd : aqt_pkg::DirBwd;
            2'b01:   direction = (new_a == new_b) ? aqt_pkg::DirBwd : aqt_pkg::DirFwd;
            default: direction = aqt_pkg::DirNone;
        endcase
    end

endmodule

// ===== rtl/analog_quadrature_tracker.sv =====
// analog quadrature tracker, top level: config registers, handshake, lanes, output
// depends on aqt_pkg, aqt_lane, aqt_merge and analog_quadrature_tracker_assert.svh
//
// usage
// - input channel: sample_valid / sample_stall carry one paired request
//   (sample_a, sample_b); a request is taken at a rising edge with
//   sample_valid high and sample_stall low
// - output channel: result_valid / result_stall carry direction (+1, -1, 0)
//   and the binarised levels level_a, level_b, one result per request, in order
// - config port: apb-style, decay_shift at byte address 0, min_height at 4;
//   pready is tied high, reads return the register value; write only when idle
// - pipeline: a taken request is registered into the binarising stage, then
//   into the output register, where it waits until result_stall is low
// - throughput: one request per cycle unless sample_stall is high; each lane's
//   envelope update is a single loop (compare, residual add, barrel shift, envelope
//   add), the hysteresis decision a second stage with the level as its own loop
// - stalls: the output register holds while result_stall is high; the middle
//   stage then fills and sample_stall rises once both stages hold a result
// - reset: envelopes, residuals, levels and the primed flag clear; the first
//   request after reset loads both envelopes of each channel with its sample
`include "analog_quadrature_tracker_assert.svh"

module analog_quadrature_tracker (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [aqt_pkg::AddrBits-1:0]   paddr,
    input  logic [aqt_pkg::DataBits-1:0]   pwdata,
    output logic [aqt_pkg::DataBits-1:0]   prdata,
    output logic                           pready,
    // request channel
    input  logic                           sample_valid,
    output logic                           sample_stall,
    input  logic [aqt_pkg::SampleBits-1:0] sample_a,
    input  logic [aqt_pkg::SampleBits-1:0] sample_b,
    // result channel
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic signed [1:0]              direction,
    output logic                           level_a,
    output logic                           level_b
);

    // configuration registers
    logic [aqt_pkg::ShiftBits-1:0]  decay_shift_reg, decay_shift_next;
    logic [aqt_pkg::HeightBits-1:0] min_height_reg, min_height_next;
    logic                           cfg_write;

    // control state
    logic primed_reg, primed_next;
    logic mid_valid_reg, mid_valid_next;   // binarising stage holds a request
    logic out_valid_reg, out_valid_next;

    // output payload
    logic signed [1:0] direction_reg;
    logic              level_a_reg, level_b_reg;

    logic               out_free;
    aqt_pkg::lane_ctrl_t ctrl;
    logic               old_a, new_a, old_b, new_b;
    logic signed [1:0]  dir_merge;

    // apb register file, pready tied high so the access phase never waits
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_comb
    begin
        decay_shift_next = decay_shift_reg;
        min_height_next  = min_height_reg;
        if (cfg_write)
        begin
            unique case (paddr[2])
                aqt_pkg::RegDecayShift:
                    decay_shift_next = pwdata[aqt_pkg::ShiftBits-1:0];
                aqt_pkg::RegMinHeight:
                    min_height_next = pwdata[aqt_pkg::HeightBits-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            aqt_pkg::RegDecayShift: prdata = aqt_pkg::DataBits'(decay_shift_reg);
            aqt_pkg::RegMinHeight:  prdata = aqt_pkg::DataBits'(min_height_reg);
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_shift_reg <= aqt_pkg::DecayShiftReset;
            min_height_reg  <= aqt_pkg::MinHeightReset;
        end
        else
        begin
            decay_shift_reg <= decay_shift_next;
            min_height_reg  <= min_height_next;
        end
    end

    // pipeline flow: output register frees when empty or taken this cycle
    assign out_free     = !out_valid_reg || !result_stall;
    assign ctrl.advance = mid_valid_reg && out_free;
    assign sample_stall = mid_valid_reg && !out_free;
    assign ctrl.load    = sample_valid && !sample_stall;
    assign ctrl.prime   = !primed_reg;

    always_comb
    begin
        primed_next    = primed_reg | ctrl.load;
        mid_valid_next = ctrl.load ? 1'b1 : (ctrl.advance ? 1'b0 : mid_valid_reg);
        out_valid_next = ctrl.advance ? 1'b1 : (out_free ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg    <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            primed_reg    <= primed_next;
            mid_valid_reg <= mid_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // one lane per sensor channel
    aqt_lane u_lane_a (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .decay_shift (decay_shift_reg),
        .min_height  (min_height_reg),
        .sample      (sample_a),
        .level_old   (old_a),
        .level_new   (new_a)
    );

    aqt_lane u_lane_b (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .decay_shift (decay_shift_reg),
        .min_height  (min_height_reg),
        .sample      (sample_b),
        .level_old   (old_b),
        .level_new   (new_b)
    );

    // quadrature decode across both lanes
    aqt_merge u_merge (
        .old_a     (old_a),
        .old_b     (old_b),
        .new_a     (new_a),
        .new_b     (new_b),
        .direction (dir_merge)
    );

    // output register, loaded as the binarising stage advances
    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            direction_reg <= dir_merge;
            level_a_reg   <= new_a;
            level_b_reg   <= new_b;
        end
    end

    assign result_valid = out_valid_reg;
    assign direction    = direction_reg;
    assign level_a      = level_a_reg;
    assign level_b      = level_b_reg;

    // a step is reported exactly when one of the two levels flips
    `AQT_ASSERT_NOW(a_step_one_flip, ctrl.advance,
        ((dir_merge != aqt_pkg::DirNone) == ($countones({new_a ^ old_a, new_b ^ old_b}) == 1)))

    // an accepted request always reaches the binarising stage
    `AQT_ASSERT_NEXT(a_load_fills_mid, ctrl.load, mid_valid_reg)

    // priming happens once per reset
    `AQT_ASSERT_NEXT(a_primed_sticks, primed_reg, primed_reg)

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for analog_quadrature_tracker: envelope, hysteresis and step decode
// depends on aqt_pkg and the rtl of analog_quadrature_tracker; stands alone otherwise
`timescale 1ns / 1ps

module testbench;
    import aqt_pkg::*;

    // run limits, in clock cycles
    localparam int LimitCycles = 1000000;
    localparam int DrainCycles = 4;       // margin for the pipe to empty after the last result

    // byte addresses of the two registers, one word apart
    localparam logic [AddrBits-1:0] AddrDecayShift = {RegDecayShift, 2'b00};
    localparam logic [AddrBits-1:0] AddrMinHeight  = {RegMinHeight, 2'b00};

    // one expected result: quadrature step plus both binarised levels
    typedef struct packed {
        logic signed [1:0] dir;
        logic              lvl_a;
        logic              lvl_b;
    } step_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [AddrBits-1:0]  paddr = '0;
    logic [DataBits-1:0]  pwdata = '0;
    logic [DataBits-1:0]  prdata;
    logic                 pready;

    logic                 sample_valid = 1'b0;
    logic                 sample_stall;
    sample_t              sample_a = '0;
    sample_t              sample_b = '0;

    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic signed [1:0]    direction;
    logic                 level_a;
    logic                 level_b;

    analog_quadrature_tracker u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_a     (sample_a),
        .sample_b     (sample_b),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .direction    (direction),
        .level_a      (level_a),
        .level_b      (level_b)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor state: register copies and the tracker's own state,
    // index 0 is channel a, index 1 is channel b
    // ------------------------------------------------------------------
    logic [ShiftBits-1:0]  shift_setting;
    logic [HeightBits-1:0] height_floor;
    bit                    seen_first;
    sample_t               floor_env [2];
    sample_t               ceil_env [2];
    residual_t             floor_rest [2];
    residual_t             ceil_rest [2];
    bit [1:0]              held_level;

    step_t pending_steps [$];      // steps predicted but not yet seen on the output
    step_t oldest_step;
    int    mismatches = 0;
    int    cycle_count = 0;
    bit    quiet = 1'b0;           // when set neither side idles nor stalls
    int    stall_left = 0;
    bit    stalling = 1'b0;

    // envelope follow for one channel: a new extreme is taken at once, otherwise
    // the distance piles up in the residual and the envelope creeps by its top bits
    function automatic void follow_envelope(int ch, sample_t s);
        residual_t keep;
        keep = (residual_t'(1) << shift_setting) - residual_t'(1);
        if (s < floor_env[ch])
            floor_env[ch] = s;
        else
            floor_rest[ch] = floor_rest[ch] + (residual_t'(s) - residual_t'(floor_env[ch]));
        if (s > ceil_env[ch])
            ceil_env[ch] = s;
        else
            ceil_rest[ch] = ceil_rest[ch] + (residual_t'(ceil_env[ch]) - residual_t'(s));
        floor_env[ch] = floor_env[ch] + sample_t'(floor_rest[ch] >> shift_setting);
        floor_rest[ch] = floor_rest[ch] & keep;
        ceil_env[ch] = ceil_env[ch] - sample_t'(ceil_rest[ch] >> shift_setting);
        ceil_rest[ch] = ceil_rest[ch] & keep;
    endfunction

    // hysteresis at a quarter of the height from each end; too flat keeps the level
    function automatic bit binarise(bit was, sample_t s, sample_t lo, sample_t hi);
        int span;
        if (hi < lo)
            return was;
        span = int'(hi) - int'(lo);
        if (span < int'(height_floor))
            return was;
        if (int'(s) < int'(lo) + span / 4)
            return 1'b0;
        if (int'(s) > int'(hi) - span / 4)
            return 1'b1;
        return was;
    endfunction

    // works out the step for one accepted request and advances the state
    function automatic step_t decode_step(sample_t a, sample_t b);
        step_t r;
        bit    new_a;
        bit    new_b;
        bit    moved_a;
        bit    moved_b;
        if (!seen_first)
        begin
            // first request since reset loads both envelopes of each channel
            seen_first = 1'b1;
            floor_env[0] = a;
            ceil_env[0] = a;
            floor_env[1] = b;
            ceil_env[1] = b;
            floor_rest = '{2{'0}};
            ceil_rest = '{2{'0}};
            held_level = '0;
        end
        follow_envelope(0, a);
        follow_envelope(1, b);
        new_a = binarise(held_level[0], a, floor_env[0], ceil_env[0]);
        new_b = binarise(held_level[1], b, floor_env[1], ceil_env[1]);
        moved_a = new_a != held_level[0];
        moved_b = new_b != held_level[1];
        r.dir = DirNone;
        if (moved_a && !moved_b)
            r.dir = (new_a == new_b) ? DirFwd : DirBwd;
        else if (moved_b && !moved_a)
            r.dir = (new_a == new_b) ? DirBwd : DirFwd;
        r.lvl_a = new_a;
        r.lvl_b = new_b;
        held_level = {new_b, new_a};
        return r;
    endfunction

    // idle lengths: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int roll;
        if (quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // ------------------------------------------------------------------
    // result side: check each accepted result against the oldest step,
    // then decide the stall for the next cycle
    // ------------------------------------------------------------------
    task automatic check_field(string what, logic [1:0] want, logic [1:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: %s mismatch, expected %b, got %b", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_steps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 40)
                    $display("%0t: result with no request outstanding, expected none, got %b %b %b",
                             $time, direction, level_a, level_b);
            end
            else
            begin
                oldest_step = pending_steps.pop_front();
                check_field("direction", oldest_step.dir, direction);
                check_field("level_a", {1'b0, oldest_step.lvl_a}, {1'b0, level_a});
                check_field("level_b", {1'b0, oldest_step.lvl_b}, {1'b0, level_b});
            end
        end
        // alternate stall and run stretches of random length
        if (stall_left > 0)
            stall_left--;
        else
        begin
            stalling = quiet ? 1'b0 : !stalling;
            stall_left = stalling ? pick_gap() : $urandom_range(0, 6);
        end
        result_stall <= stalling && !quiet;
    end

    // watchdog
    initial
    begin
        while (cycle_count < LimitCycles)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // request side helpers; every task starts and ends just after a rising edge
    // ------------------------------------------------------------------

    // random idle after a request, payload wanders while valid is low
    task automatic pace_sender();
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            sample_a <= sample_t'($urandom);
            sample_b <= sample_t'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    // present one paired request, wait until it is taken, record its step
    task automatic send_pair(sample_t a, sample_t b);
        sample_valid <= 1'b1;
        sample_a <= a;
        sample_b <= b;
        do
            @(posedge clk);
        while (sample_stall);
        pending_steps.push_back(decode_step(a, b));
        pace_sender();
    endtask

    // stop sending and wait for every outstanding result, then let the pipe empty
    task automatic settle_block();
        sample_valid <= 1'b0;
        while (pending_steps.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // apb write: setup cycle, access cycle, written on the edge with pready high;
    // bits above the register width carry junk to show that they are ignored
    task automatic write_register(logic [AddrBits-1:0] addr, int unsigned value);
        logic [DataBits-1:0] word;
        word = $urandom;
        if (addr == AddrMinHeight)
        begin
            word[HeightBits-1:0] = value[HeightBits-1:0];
            height_floor = value[HeightBits-1:0];
        end
        else
        begin
            word[ShiftBits-1:0] = value[ShiftBits-1:0];
            shift_setting = value[ShiftBits-1:0];
        end
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        pwdata <= $urandom;
        // return to idle before the next transfer
        @(posedge clk);
    endtask

    // triangle wave point with optional jitter, clipped to the converter range
    function automatic sample_t wave_point(int p, int period, int mid, int amp, int jitter);
        int q;
        int v;
        int noise;
        int x;
        q = ((p % period) + period) % period;
        v = (q < period / 2) ? q : period - q;
        noise = $urandom_range(0, 2 * jitter);
        noise -= jitter;
        x = mid - amp + (2 * amp * v) / (period / 2) + noise;
        if (x < 0)
            x = 0;
        if (x > 4095)
            x = 4095;
        return sample_t'(x);
    endfunction

    // the converter extremes and their neighbours in four draws of ten, otherwise anything
    function automatic sample_t extreme_or_random();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return sample_t'(1);
            3: return sample_t'(4094);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // a rotating quadrature pair with random speed, reversals, jitter and the odd glitch
    task automatic send_wave(int count);
        int period;
        int amp;
        int mid;
        int jitter;
        int phase;
        int heading;
        period = 2 * $urandom_range(8, 48);
        amp = ($urandom_range(0, 9) < 8) ? $urandom_range(300, 2047) : $urandom_range(10, 200);
        mid = $urandom_range(amp, 4095 - amp);
        jitter = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        phase = $urandom_range(0, period - 1);
        heading = $urandom_range(0, 1) ? 1 : -1;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 4)
                send_pair(sample_t'($urandom), sample_t'($urandom));
            else
                send_pair(wave_point(phase, period, mid, amp, jitter),
                          wave_point(phase + period / 4, period, mid, amp, jitter));
            if ($urandom_range(0, 99) < 5)
                heading = -heading;
            phase += heading * $urandom_range(0, 3);
        end
    endtask

    // random register setting for one phase, extremes included
    task automatic pick_config();
        int roll;
        int floor_pick;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            floor_pick = 0;
        else if (roll < 3)
            floor_pick = $urandom_range(1, 255);
        else if (roll < 7)
            floor_pick = $urandom_range(256, 1500);
        else if (roll < 9)
            floor_pick = $urandom_range(1501, 4094);
        else
            floor_pick = 4095;
        write_register(AddrDecayShift, $urandom_range(0, 15));
        write_register(AddrMinHeight, floor_pick);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // first request loads the envelopes, then full-swing steps in both
    // directions, both channels moving at once, no movement, mid-scale
    task automatic test_first_sample();
        sample_t seq_a [20] = '{0, 4095, 4095, 0, 0, 4095, 4095, 0, 0, 4095,
                                4095, 0, 4095, 4095, 4095, 2048, 4095, 0, 1, 4094};
        sample_t seq_b [20] = '{4095, 4095, 0, 0, 4095, 4095, 0, 0, 4095, 4095,
                                0, 4095, 0, 0, 0, 2048, 0, 4095, 4094, 1};
        for (int i = 0; i < 20; i++)
            send_pair(seq_a[i], seq_b[i]);
        settle_block();
    endtask

    // registers at their extremes: fastest decay and no height floor, then the
    // slowest decay with a floor that only a full swing reaches
    task automatic test_register_extremes();
        write_register(AddrDecayShift, 0);
        write_register(AddrMinHeight, 0);
        send_wave(40);
        settle_block();
        write_register(AddrDecayShift, 15);
        write_register(AddrMinHeight, 4095);
        for (int i = 0; i < 40; i++)
            send_pair((i % 4) < 2 ? sample_t'(4095) : sample_t'(0),
                      ((i + 1) % 4) < 2 ? sample_t'(4095) : sample_t'(0));
        settle_block();
    endtask

    // bulk of the run: quadrature waves under a new setting each phase;
    // the sender drains the block before every register change
    task automatic test_quadrature_phases();
        repeat (12)
        begin
            pick_config();
            send_wave(120);
            settle_block();
        end
    endtask

    // uncorrelated samples, biased toward the converter limits
    task automatic test_sample_noise();
        pick_config();
        for (int i = 0; i < 150; i++)
            send_pair(extreme_or_random(), extreme_or_random());
        settle_block();
    endtask

    // one request per cycle with the output never stalled
    task automatic test_back_to_back();
        write_register(AddrDecayShift, 2);
        write_register(AddrMinHeight, 128);
        quiet = 1'b1;
        send_wave(120);
        settle_block();
        quiet = 1'b0;
    endtask

    initial
    begin
        shift_setting = DecayShiftReset;
        height_floor = MinHeightReset;
        seen_first = 1'b0;
        floor_env = '{2{'0}};
        ceil_env = '{2{'0}};
        floor_rest = '{2{'0}};
        ceil_rest = '{2{'0}};
        held_level = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_sample();
        test_register_extremes();
        test_quadrature_phases();
        test_sample_noise();
        test_back_to_back();

        settle_block();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_steps.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/aqt_pkg.sv
rtl/aqt_lane.sv
rtl/aqt_merge.sv
rtl/analog_quadrature_tracker.sv
sim/testbench.sv
